[hw/rtl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64url stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CNT_OUT_W       = 16;
    localparam int BYTE_W          = 8;
    localparam int SEXTET_W        = 6;

    // input word
    typedef struct packed {
        logic [BYTE_W-1:0] text_char;
        logic              end_of_text;
    } t_in_item;

    // result word
    typedef struct packed {
        logic [BYTE_W-1:0]    data_byte;
        logic                 byte_valid;
        logic                 final_result;
        logic [CNT_OUT_W-1:0] accepted_count;
    } t_out_item;

    // one decoded group: up to three result words from up to four input words
    typedef struct packed {
        logic [3*BYTE_W-1:0]  bytes;     // first byte in the top lane
        logic [1:0]           nres;      // result words, 1..3
        logic                 valid;     // bytes carry data
        logic                 fin;       // group ends a string
        logic [CNT_OUT_W-1:0] cnt;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front
// Maps characters to sextets, collects them and emits decoded groups.
// ----------------------------------------------------------------------------
module b64d_front #(
    parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64d_pkg::t_in_item  i_item,
    input  b64d_pkg::t_q_status i_q,
    output logic                o_full,
    output logic                o_wr,
    output b64d_pkg::t_group    o_group
);
    import b64d_pkg::*;

    localparam logic [SEXTET_W-1:0] CODE_DASH  = SEXTET_W'(62);
    localparam logic [SEXTET_W-1:0] CODE_UNDER = SEXTET_W'(63);

    function automatic logic [SEXTET_W:0] map_char(input logic [BYTE_W-1:0] c);
        logic [SEXTET_W:0] r;
        r = '0;
        if (c >= "A" && c <= "Z") begin
            r = {1'b1, SEXTET_W'(c - 8'd65)};
        end else if (c >= "a" && c <= "z") begin
            r = {1'b1, SEXTET_W'(c - 8'd71)};
        end else if (c >= "0" && c <= "9") begin
            r = {1'b1, SEXTET_W'(c + 8'd4)};
        end else if (c == "-") begin
            r = {1'b1, CODE_DASH};
        end else if (c == "_") begin
            r = {1'b1, CODE_UNDER};
        end
        return r;
    endfunction

    logic [3*SEXTET_W-1:0] r_acc, n_acc;
    logic [1:0]            r_sc, n_sc;
    logic                  r_stop, n_stop;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [CNT_OUT_W-1:0]  rep_cnt;
    logic [SEXTET_W:0]     mapped;
    logic                  accept;

    assign o_full = i_q.full;
    assign accept = i_push && !i_q.full;
    assign mapped = map_char(i_item.text_char);

    // clamp the reported count to the result field
    generate
        if (COUNT_WIDTH > CNT_OUT_W) begin : g_clamp
            assign rep_cnt = (|r_cnt[COUNT_WIDTH-1:CNT_OUT_W]) ? '1
                                                               : r_cnt[CNT_OUT_W-1:0];
        end else begin : g_ext
            assign rep_cnt = CNT_OUT_W'(r_cnt);
        end
    endgenerate

    always_comb begin
        n_acc   = r_acc;
        n_sc    = r_sc;
        n_stop  = r_stop;
        n_cnt   = r_cnt;
        o_wr    = 1'b0;
        o_group = '0;
        if (accept) begin
            if (i_item.end_of_text) begin
                o_wr        = 1'b1;
                o_group.fin = 1'b1;
                o_group.cnt = rep_cnt;
                unique case (r_sc)
                    2'd2: begin
                        o_group.bytes = {r_acc[11:4], 16'h0000};
                        o_group.nres  = 2'd1;
                        o_group.valid = 1'b1;
                    end
                    2'd3: begin
                        o_group.bytes = {r_acc[17:10], r_acc[9:2], 8'h00};
                        o_group.nres  = 2'd2;
                        o_group.valid = 1'b1;
                    end
                    default: begin
                        o_group.nres  = 2'd1;
                    end
                endcase
                // back to the start of a new string
                n_acc  = '0;
                n_sc   = '0;
                n_stop = 1'b0;
                n_cnt  = '0;
            end else if (!r_stop) begin
                if (!mapped[SEXTET_W]) begin
                    n_stop = 1'b1;
                end else begin
                    if (!(&r_cnt)) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (r_sc == 2'd3) begin
                        o_wr          = 1'b1;
                        o_group.bytes = {r_acc, mapped[SEXTET_W-1:0]};
                        o_group.nres  = 2'd3;
                        o_group.valid = 1'b1;
                        n_acc         = '0;
                        n_sc          = '0;
                    end else begin
                        n_acc = {r_acc[2*SEXTET_W-1:0], mapped[SEXTET_W-1:0]};
                        n_sc  = r_sc + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_sc   <= '0;
            r_stop <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_acc  <= n_acc;
            r_sc   <= n_sc;
            r_stop <= n_stop;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
// ----------------------------------------------------------------------------
// b64d_queue
// Short group queue between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  b64d_pkg::t_group    i_wr_data,
    input  logic                i_rd,
    output b64d_pkg::t_group    o_rd_data,
    output b64d_pkg::t_q_status o_status
);
    import b64d_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_group           r_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] r_wp, n_wp;
    logic [IDX_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_rd_data      = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_wr) begin
            n_wp = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_wr || i_rd)
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_rd)
        else $error("group queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && !i_rd |=> r_count == $past(r_count) + 1'b1)
        else $error("group queue fill count lost a write");
`endif

endmodule

[hw/rtl/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks queued groups into result words, one word per cycle while i_pop is high.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_group    i_group,
    input  b64d_pkg::t_q_status i_q,
    output logic                o_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output b64d_pkg::t_out_item o_res
);
    import b64d_pkg::*;

    t_group     r_entry;
    logic [1:0] r_idx, n_idx;
    logic       r_busy, n_busy;
    logic       last;

    assign last    = (r_idx == 2'(r_entry.nres - 2'd1));
    assign o_empty = !r_busy;
    // load the next group when idle or when the last word leaves
    assign o_rd    = !i_q.empty && (!r_busy || (i_pop && last));

    always_comb begin
        n_idx  = r_idx;
        n_busy = r_busy;
        if (o_rd) begin
            n_idx  = '0;
            n_busy = 1'b1;
        end else if (r_busy && i_pop) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_comb begin
        o_res = '0;
        unique case (r_idx)
            2'd0:    o_res.data_byte = r_entry.bytes[23:16];
            2'd1:    o_res.data_byte = r_entry.bytes[15:8];
            default: o_res.data_byte = r_entry.bytes[7:0];
        endcase
        o_res.byte_valid   = r_entry.valid;
        o_res.final_result = r_entry.fin && last;
        o_res.accepted_count = (r_entry.fin && last) ? r_entry.cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_entry <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < r_entry.nres)
        else $error("word index ran past the group");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_pop |=> r_busy && $stable(r_idx))
        else $error("stalled result word moved");
`endif

endmodule

[hw/rtl/base64url_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// base64url_stream_decoder_core
// Base64url text in, decoded bytes out, one character per input word.
// ----------------------------------------------------------------------------
// Input side: drive i_item and raise push; a word is taken on a clock edge
// with push high and full low. A word with end_of_text set flushes the
// tail and closes the string; its last result carries the character count.
// Result side: while empty is low, o_res holds the oldest result word; it
// leaves on an edge with pop high.
// A group is written into the group queue, then loaded into the back's
// entry register before its first word shows on o_res. The front takes
// one character per cycle while full is low; four characters give three
// result words, which the back hands out one per cycle while pop is high,
// so the input side sets the sustained rate: about 0.75 bytes per character.
// When the receiver stalls, groups collect in the group queue (QUEUE_DEPTH
// entries) and full rises once it is full; characters that give no result
// still wait for a free entry.
// Reset clears the decode state, the count and the queue; no result is
// pending afterward and the block takes input at once.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_core #(
    parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::t_out_item o_res
);
    import b64d_pkg::*;

    t_q_status q_status;
    t_group    wr_group;
    t_group    rd_group;
    logic      wr;
    logic      rd;

    b64d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_q     (q_status),
        .o_full  (full),
        .o_wr    (wr),
        .o_group (wr_group)
    );

    b64d_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_data (wr_group),
        .i_rd      (rd),
        .o_rd_data (rd_group),
        .o_status  (q_status)
    );

    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_group (rd_group),
        .i_q     (q_status),
        .o_rd    (rd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (o_res)
    );

endmodule
